// File: src/rcs_pkg.sv
// Shared types and constants for the rectangle cutout splitter.
// No dependencies; every other file in src/ refers to it by scoped names.
package rcs_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int SIZE_WIDTH  = 15;
    // Edges carry a coordinate plus a size at full precision.
    localparam int EDGE_WIDTH  =
        ((COORD_WIDTH > SIZE_WIDTH) ? COORD_WIDTH : SIZE_WIDTH + 1) + 1;
    localparam int NUM_PIECES  = 4;
    localparam int PIECE_IDX_WIDTH = $clog2(NUM_PIECES);

    // Band slot order: top, left middle, right middle, bottom.
    localparam int SLOT_TOP    = 0;
    localparam int SLOT_LEFT   = 1;
    localparam int SLOT_RIGHT  = 2;
    localparam int SLOT_BOTTOM = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [SIZE_WIDTH-1:0]  sz_t;
    typedef logic signed [EDGE_WIDTH-1:0]  edge_t;
    typedef logic        [NUM_PIECES-1:0]  piece_mask_t;

    typedef struct packed {
        coord_t src_x;
        coord_t src_y;
        sz_t    src_w;
        sz_t    src_h;
        coord_t cut_x;
        coord_t cut_y;
        sz_t    cut_w;
        sz_t    cut_h;
    } rect_req_t;

    typedef struct packed {
        coord_t piece_x;
        coord_t piece_y;
        sz_t    piece_w;
        sz_t    piece_h;
        logic   piece_last;
    } piece_t;

    typedef struct packed {
        edge_t ix1;
        edge_t iy1;
        edge_t ix2;
        edge_t iy2;
        edge_t cx1;
        edge_t cy1;
        edge_t cx2;
        edge_t cy2;
        sz_t   iw;
    } edges_t;

    typedef struct packed {
        edges_t e;
        edge_t  mtop;
        edge_t  mbot;
        logic   overlap;
        logic   left;
        logic   right;
        logic   top;
        logic   bottom;
    } class_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        sz_t    w;
        sz_t    h;
    } rect_t;

    typedef struct packed {
        rect_t [NUM_PIECES-1:0] slot;
        piece_mask_t            mask;
    } bands_t;

endpackage

// File: src/rcs_edges.sv
// Stage 1: register the request and form the right and bottom edges.
// Depends on rcs_pkg.
module rcs_edges
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               feed,
    input  rcs_pkg::rect_req_t req,
    output logic               staged,
    output rcs_pkg::edges_t    edges
);

    logic            valid_reg;
    rcs_pkg::edges_t edges_reg;
    rcs_pkg::edges_t edges_next;

    always_comb
    begin
        edges_next.ix1 = rcs_pkg::edge_t'(req.src_x);
        edges_next.iy1 = rcs_pkg::edge_t'(req.src_y);
        edges_next.cx1 = rcs_pkg::edge_t'(req.cut_x);
        edges_next.cy1 = rcs_pkg::edge_t'(req.cut_y);
        edges_next.ix2 = rcs_pkg::edge_t'(req.src_x) + rcs_pkg::edge_t'(req.src_w);
        edges_next.iy2 = rcs_pkg::edge_t'(req.src_y) + rcs_pkg::edge_t'(req.src_h);
        edges_next.cx2 = rcs_pkg::edge_t'(req.cut_x) + rcs_pkg::edge_t'(req.cut_w);
        edges_next.cy2 = rcs_pkg::edge_t'(req.cut_y) + rcs_pkg::edge_t'(req.cut_h);
        edges_next.iw  = req.src_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= feed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && feed)
        begin
            edges_reg <= edges_next;
        end
    end

    assign staged = valid_reg;
    assign edges  = edges_reg;

endmodule

// File: src/rcs_classify.sv
// Stage 2: overlap test, stick-out flags and middle band rows.
// Depends on rcs_pkg.
module rcs_classify
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            feed,
    input  rcs_pkg::edges_t edges,
    output logic            staged,
    output rcs_pkg::class_t cls
);

    logic            valid_reg;
    rcs_pkg::class_t cls_reg;
    rcs_pkg::class_t cls_next;

    always_comb
    begin
        cls_next.e       = edges;
        // Strict half-open intersection on both axes.
        cls_next.overlap = (edges.cx1 < edges.ix2) && (edges.ix1 < edges.cx2) &&
                           (edges.cy1 < edges.iy2) && (edges.iy1 < edges.cy2);
        cls_next.left    = edges.ix1 < edges.cx1;
        cls_next.right   = edges.ix2 > edges.cx2;
        cls_next.top     = edges.iy1 < edges.cy1;
        cls_next.bottom  = edges.iy2 > edges.cy2;
        cls_next.mtop    = (edges.iy1 < edges.cy1) ? edges.cy1 : edges.iy1;
        cls_next.mbot    = (edges.iy2 > edges.cy2) ? edges.cy2 : edges.iy2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= feed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && feed)
        begin
            cls_reg <= cls_next;
        end
    end

    assign staged = valid_reg;
    assign cls    = cls_reg;

endmodule

// File: src/rcs_bands.sv
// Stage 3: build the four candidate bands and the mask of those present.
// Depends on rcs_pkg.
module rcs_bands
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            feed,
    input  rcs_pkg::class_t cls,
    output logic            staged,
    output rcs_pkg::bands_t bands
);

    logic            valid_reg;
    rcs_pkg::bands_t bands_reg;
    rcs_pkg::bands_t bands_next;
    rcs_pkg::edge_t  mid_h;
    rcs_pkg::coord_t src_x;
    rcs_pkg::coord_t src_y;

    always_comb
    begin
        mid_h = cls.mbot - cls.mtop;
        src_x = cls.e.ix1[rcs_pkg::COORD_WIDTH-1:0];
        src_y = cls.e.iy1[rcs_pkg::COORD_WIDTH-1:0];

        bands_next.slot[rcs_pkg::SLOT_TOP].x = src_x;
        bands_next.slot[rcs_pkg::SLOT_TOP].y = src_y;
        bands_next.slot[rcs_pkg::SLOT_TOP].w = cls.e.iw;
        bands_next.slot[rcs_pkg::SLOT_TOP].h =
            rcs_pkg::SIZE_WIDTH'(cls.e.cy1 - cls.e.iy1);

        bands_next.slot[rcs_pkg::SLOT_LEFT].x = src_x;
        bands_next.slot[rcs_pkg::SLOT_LEFT].y = cls.mtop[rcs_pkg::COORD_WIDTH-1:0];
        bands_next.slot[rcs_pkg::SLOT_LEFT].w =
            rcs_pkg::SIZE_WIDTH'(cls.e.cx1 - cls.e.ix1);
        bands_next.slot[rcs_pkg::SLOT_LEFT].h = mid_h[rcs_pkg::SIZE_WIDTH-1:0];

        bands_next.slot[rcs_pkg::SLOT_RIGHT].x = cls.e.cx2[rcs_pkg::COORD_WIDTH-1:0];
        bands_next.slot[rcs_pkg::SLOT_RIGHT].y = cls.mtop[rcs_pkg::COORD_WIDTH-1:0];
        bands_next.slot[rcs_pkg::SLOT_RIGHT].w =
            rcs_pkg::SIZE_WIDTH'(cls.e.ix2 - cls.e.cx2);
        bands_next.slot[rcs_pkg::SLOT_RIGHT].h = mid_h[rcs_pkg::SIZE_WIDTH-1:0];

        bands_next.slot[rcs_pkg::SLOT_BOTTOM].x = src_x;
        bands_next.slot[rcs_pkg::SLOT_BOTTOM].y = cls.e.cy2[rcs_pkg::COORD_WIDTH-1:0];
        bands_next.slot[rcs_pkg::SLOT_BOTTOM].w = cls.e.iw;
        bands_next.slot[rcs_pkg::SLOT_BOTTOM].h =
            rcs_pkg::SIZE_WIDTH'(cls.e.iy2 - cls.e.cy2);

        bands_next.mask = {cls.bottom, cls.right, cls.left, cls.top};

        // Disjoint rectangles: pass the source through unchanged.
        if (!cls.overlap)
        begin
            bands_next.slot[rcs_pkg::SLOT_TOP].h =
                rcs_pkg::SIZE_WIDTH'(cls.e.iy2 - cls.e.iy1);
            bands_next.mask = rcs_pkg::piece_mask_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= feed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && feed)
        begin
            bands_reg <= bands_next;
        end
    end

    assign staged = valid_reg;
    assign bands  = bands_reg;

endmodule

// File: src/rcs_serial.sv
// Output stage: emit the present bands of one request, one per cycle, in order.
// Depends on rcs_pkg.
module rcs_serial
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            feed,
    input  rcs_pkg::bands_t bands,
    output logic            ready,
    output logic            done,
    output rcs_pkg::piece_t piece
);

    rcs_pkg::piece_mask_t                    mask_reg;
    rcs_pkg::piece_mask_t                    mask_next;
    rcs_pkg::rect_t [rcs_pkg::NUM_PIECES-1:0] slot_reg;
    logic                                    done_reg;
    rcs_pkg::piece_t                         piece_reg;
    rcs_pkg::piece_t                         piece_next;
    logic [rcs_pkg::PIECE_IDX_WIDTH-1:0]     pick;
    rcs_pkg::piece_mask_t                    remain;
    logic                                    load;

    always_comb
    begin
        pick = '0;
        for (int i = rcs_pkg::NUM_PIECES - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick = rcs_pkg::PIECE_IDX_WIDTH'(i);
            end
        end
        remain = mask_reg & ~(rcs_pkg::piece_mask_t'(1) << pick);
        // Take the next request once at most one piece is left to send.
        ready  = (remain == '0);
        load   = feed && ready;
        mask_next = load ? bands.mask : remain;

        piece_next.piece_x    = slot_reg[pick].x;
        piece_next.piece_y    = slot_reg[pick].y;
        piece_next.piece_w    = slot_reg[pick].w;
        piece_next.piece_h    = slot_reg[pick].h;
        piece_next.piece_last = (remain == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            done_reg <= (mask_reg != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= bands.slot;
        end
        if (mask_reg != '0)
        begin
            piece_reg <= piece_next;
        end
    end

    assign done  = done_reg;
    assign piece = piece_reg;

endmodule

// File: src/rect_cutout_split_top.sv
// Rectangle cutout splitter, top level. Depends on rcs_pkg and the rcs_* stages.
//
// Subtracts a cutout rectangle from a source rectangle and returns zero to four
// pieces that cover what is left: top band, left middle band, right middle band,
// bottom band, in that order, the final one flagged with piece_last. Disjoint
// rectangles return the source unchanged; a full cover returns nothing. A request
// is taken at a rising edge with start high and busy low. Each piece is on the
// piece port for exactly one cycle while done is high; the receiver cannot hold
// pieces off, so it must take one every cycle that done is high. A request
// passes through the edge, classify and band registers and the output stage's mask
// and piece registers before its first piece appears. Throughput is set by the
// output port, which sends one piece per cycle and takes the next request once
// at most one piece of the current one is left to send, so pass-through requests
// are accepted every cycle. Between the intake and the output sit three pipeline
// stages (edge sums, compares, band arithmetic); they hold when the output stage
// is full, and busy reflects that backpressure.
module rect_cutout_split_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rcs_pkg::rect_req_t req,
    output logic               done,
    output rcs_pkg::piece_t    piece
);

    logic            s1_valid;
    logic            s2_valid;
    logic            s3_valid;
    logic            ser_ready;
    logic            adv1;
    logic            adv2;
    logic            adv3;
    rcs_pkg::edges_t s1_edges;
    rcs_pkg::class_t s2_cls;
    rcs_pkg::bands_t s3_bands;

    // Advance a stage when it is empty or the stage after it advances.
    assign adv3 = !s3_valid || ser_ready;
    assign adv2 = !s2_valid || adv3;
    assign adv1 = !s1_valid || adv2;
    assign busy = !adv1;

    rcs_edges u_edges
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (adv1),
        .feed    (start),
        .req     (req),
        .staged  (s1_valid),
        .edges   (s1_edges)
    );

    rcs_classify u_classify
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (adv2),
        .feed    (s1_valid),
        .edges   (s1_edges),
        .staged  (s2_valid),
        .cls     (s2_cls)
    );

    rcs_bands u_bands
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (adv3),
        .feed    (s2_valid),
        .cls     (s2_cls),
        .staged  (s3_valid),
        .bands   (s3_bands)
    );

    // Drain the pieces of each request one per cycle.
    rcs_serial u_serial
    (
        .clk   (clk),
        .rst_n (rst_n),
        .feed  (s3_valid),
        .bands (s3_bands),
        .ready (ser_ready),
        .done  (done),
        .piece (piece)
    );

endmodule
